[rtl/trlp_pkg.sv]
`default_nettype none

package trlp_pkg;

    localparam int FILE_ALIGN_DEF   = 256;
    localparam int ENTRY_BYTES_DEF  = 128;
    localparam int HEAD_BYTES_DEF   = 256;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam int MAX_DIMS  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_TABLE_BYTES = 2'd1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_PAY_OVF   = 3'd2,
        ST_AUX_OVF   = 3'd3,
        ST_TOO_LARGE = 3'd4,
        ST_ABORTED   = 3'd5
    } status_t;

    typedef struct packed {
        logic        first;
        logic [63:0] payload_bytes;
        logic [63:0] side_bytes;
        logic [31:0] align_bytes;
        logic [3:0]  dim_count;
    } in_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] payload_offset;
        logic [63:0] side_offset;
        logic [63:0] end_offset;
    } out_t;

    // Classified plan handed from front to back
    typedef struct packed {
        logic        first;
        logic        invalid;
        logic [63:0] payload_bytes;
        logic [63:0] side_bytes;
        logic [63:0] align_mask;
        logic [63:0] start;
    } plan_t;

endpackage

`default_nettype wire

[rtl/tensor_region_layout_planner.sv]
// Tensor region layout planner.
// Input queue side: drive in_item with push; the item is taken at a clock edge
// where push is high and full is low. Each plan gives exactly one result.
// Result queue side: while empty is low the oldest result sits on out_item and
// leaves at an edge where pop is high.
// Config channel: cfg_index 0 is entry_count, 1 is name_table_bytes; a write
// lands when cfg_valid and cfg_ready are high (cfg_ready is always high).
// Write config only while no plan is in flight.
// Throughput: one plan per cycle while full is low and results are popped;
// the cursor is updated by the align/add chain in the back stage. An accepted
// plan passes plan queue, back stage and result queue on its way to out_item.
// After reset and after every config write, full stays high while the start
// cursor is summed (S_SUM) and rounded up to FILE_ALIGN (S_FIX).
// Reset clears the cursor and the abort flag.
// If the receiver stops popping, the result queue fills, the back stage holds,
// the plan queue fills and full rises; nothing is dropped.
`default_nettype none

module tensor_region_layout_planner #(
    parameter int FILE_ALIGN  = trlp_pkg::FILE_ALIGN_DEF,
    parameter int ENTRY_BYTES = trlp_pkg::ENTRY_BYTES_DEF,
    parameter int HEAD_BYTES  = trlp_pkg::HEAD_BYTES_DEF,
    parameter int QUEUE_DEPTH = trlp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [trlp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [trlp_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           push,
    output logic                                full,
    input  wire trlp_pkg::in_t                  in_item,
    output logic                                empty,
    input  wire logic                           pop,
    output trlp_pkg::out_t                      out_item
);

    logic            plan_wr;
    trlp_pkg::plan_t plan_wdata;
    logic            plan_full;
    logic            plan_rd;
    trlp_pkg::plan_t plan_rdata;
    logic            plan_empty;
    logic            res_wr;
    trlp_pkg::out_t  res_wdata;
    logic            res_full;

    trlp_front #(
        .FILE_ALIGN  (FILE_ALIGN),
        .ENTRY_BYTES (ENTRY_BYTES),
        .HEAD_BYTES  (HEAD_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .plan_wr   (plan_wr),
        .plan_data (plan_wdata),
        .plan_full (plan_full)
    );

    trlp_fifo #(
        .T     (trlp_pkg::plan_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_plan_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (plan_wr),
        .wr_data (plan_wdata),
        .full    (plan_full),
        .rd_en   (plan_rd),
        .rd_data (plan_rdata),
        .empty   (plan_empty)
    );

    trlp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan_empty (plan_empty),
        .plan_data  (plan_rdata),
        .plan_rd    (plan_rd),
        .res_wr     (res_wr),
        .res_data   (res_wdata),
        .res_full   (res_full)
    );

    trlp_fifo #(
        .T     (trlp_pkg::out_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_wdata),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (out_item),
        .empty   (empty)
    );

endmodule

`default_nettype wire

[rtl/trlp_fifo.sv]
`default_nettype none

module trlp_fifo #(
    parameter type T     = trlp_pkg::plan_t,
    parameter int  DEPTH = trlp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire T     wr_data,
    output logic      full,
    input  wire logic rd_en,
    output T          rd_data,
    output logic      empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                 mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[rtl/trlp_front.sv]
`default_nettype none

module trlp_front #(
    parameter int FILE_ALIGN  = trlp_pkg::FILE_ALIGN_DEF,
    parameter int ENTRY_BYTES = trlp_pkg::ENTRY_BYTES_DEF,
    parameter int HEAD_BYTES  = trlp_pkg::HEAD_BYTES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [trlp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [trlp_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           push,
    output logic                                full,
    input  wire trlp_pkg::in_t                  in_item,
    output logic                                plan_wr,
    output trlp_pkg::plan_t                     plan_data,
    input  wire logic                           plan_full
);

    // Start-of-data sum fits in this many bits at any register value
    localparam int SUM_W = 32 + $clog2(ENTRY_BYTES) + 2;
    // FILE_ALIGN is a power of two, so rounding up is an add and a mask
    localparam logic [SUM_W-1:0] FA_MASK = SUM_W'(FILE_ALIGN - 1);

    typedef enum logic [1:0] {
        S_SUM,
        S_FIX,
        S_READY
    } start_state_t;

    start_state_t     state_reg;
    logic [31:0]      entry_count_reg;
    logic [31:0]      name_table_bytes_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [63:0]      start_reg;
    logic             cfg_fire;
    logic             busy;
    logic [63:0]      align_wide;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign busy      = (state_reg != S_READY);
    assign full      = busy || plan_full;
    assign plan_wr   = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_SUM;
            entry_count_reg      <= '0;
            name_table_bytes_reg <= '0;
            sum_reg              <= '0;
            start_reg            <= '0;
        end
        else if (cfg_fire)
        begin
            // Any config write restarts the start computation
            state_reg <= S_SUM;
            case (cfg_index)
                trlp_pkg::CFG_ENTRY_COUNT:      entry_count_reg      <= cfg_data;
                trlp_pkg::CFG_NAME_TABLE_BYTES: name_table_bytes_reg <= cfg_data;
                default:                        ;
            endcase
        end
        else
        begin
            case (state_reg)
                S_SUM:
                begin
                    sum_reg   <= SUM_W'(HEAD_BYTES)
                               + SUM_W'(entry_count_reg) * SUM_W'(ENTRY_BYTES)
                               + SUM_W'(name_table_bytes_reg);
                    state_reg <= S_FIX;
                end
                S_FIX:
                begin
                    start_reg <= 64'((sum_reg + FA_MASK) & ~FA_MASK);
                    state_reg <= S_READY;
                end
                S_READY:
                begin
                    state_reg <= S_READY;
                end
                default:
                begin
                    state_reg <= S_SUM;
                end
            endcase
        end
    end

    assign align_wide = 64'(in_item.align_bytes);

    always_comb
    begin
        plan_data.first         = in_item.first;
        plan_data.invalid       = (in_item.payload_bytes == '0)
                               || (in_item.dim_count > 4'(trlp_pkg::MAX_DIMS))
                               || (align_wide < 64'(FILE_ALIGN))
                               || ((align_wide & (align_wide - 64'd1)) != '0);
        plan_data.payload_bytes = in_item.payload_bytes;
        plan_data.side_bytes    = in_item.side_bytes;
        plan_data.align_mask    = align_wide - 64'd1;
        plan_data.start         = start_reg;
    end

    cfg_restarts_start: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> (state_reg == S_SUM))
        else $error("config write did not restart start computation");

    no_plan_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |-> !plan_wr)
        else $error("plan issued with stale start cursor");

    fix_follows_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM && !cfg_fire) |=> (state_reg == S_FIX))
        else $error("start sum not followed by rounding");

endmodule

`default_nettype wire

[rtl/trlp_back.sv]
`default_nettype none

module trlp_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            plan_empty,
    input  wire trlp_pkg::plan_t plan_data,
    output logic                 plan_rd,
    output logic                 res_wr,
    output trlp_pkg::out_t       res_data,
    input  wire logic            res_full
);

    logic [63:0]       cursor_reg;
    logic [63:0]       cursor_next;
    logic              aborted_reg;
    logic              aborted_next;
    logic              fire;
    logic [63:0]       cur;
    logic              ab;
    logic [64:0]       pay_round;
    logic [63:0]       pay_ofs;
    logic [64:0]       pay_end;
    logic [64:0]       side_round;
    logic [63:0]       side_ofs;
    logic [64:0]       side_end;
    logic              has_side;
    logic [63:0]       end_ofs;
    trlp_pkg::status_t status;

    assign fire    = !plan_empty && !res_full;
    assign plan_rd = fire;
    assign res_wr  = fire;

    assign cur = plan_data.first ? plan_data.start : cursor_reg;
    assign ab  = plan_data.first ? 1'b0 : aborted_reg;

    assign has_side   = (plan_data.side_bytes != '0);
    assign pay_round  = {1'b0, cur} + {1'b0, plan_data.align_mask};
    assign pay_ofs    = pay_round[63:0] & ~plan_data.align_mask;
    assign pay_end    = {1'b0, pay_ofs} + {1'b0, plan_data.payload_bytes};
    assign side_round = {1'b0, pay_end[63:0]} + {1'b0, plan_data.align_mask};
    assign side_ofs   = side_round[63:0] & ~plan_data.align_mask;
    assign side_end   = {1'b0, side_ofs} + {1'b0, plan_data.side_bytes};
    assign end_ofs    = has_side ? side_end[63:0] : pay_end[63:0];

    always_comb
    begin
        if (ab)
        begin
            status = trlp_pkg::ST_ABORTED;
        end
        else if (plan_data.invalid)
        begin
            status = trlp_pkg::ST_INVALID;
        end
        else if (pay_round[64] || pay_end[64])
        begin
            status = trlp_pkg::ST_PAY_OVF;
        end
        else if (has_side && (side_round[64] || side_end[64]))
        begin
            status = trlp_pkg::ST_AUX_OVF;
        end
        else if (end_ofs[63])
        begin
            status = trlp_pkg::ST_TOO_LARGE;
        end
        else
        begin
            status = trlp_pkg::ST_OK;
        end
    end

    always_comb
    begin
        res_data.status = status;
        if (status == trlp_pkg::ST_OK)
        begin
            res_data.payload_offset = pay_ofs;
            res_data.side_offset    = has_side ? side_ofs : '0;
            res_data.end_offset     = end_ofs;
        end
        else
        begin
            res_data.payload_offset = '0;
            res_data.side_offset    = '0;
            res_data.end_offset     = cur;
        end
    end

    always_comb
    begin
        cursor_next  = cursor_reg;
        aborted_next = aborted_reg;
        if (fire)
        begin
            cursor_next  = (status == trlp_pkg::ST_OK) ? end_ofs : cur;
            aborted_next = (status != trlp_pkg::ST_OK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg  <= '0;
            aborted_reg <= 1'b0;
        end
        else
        begin
            cursor_reg  <= cursor_next;
            aborted_reg <= aborted_next;
        end
    end

    ok_advances_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && status == trlp_pkg::ST_OK) |=> (cursor_reg == $past(end_ofs)))
        else $error("cursor did not advance to end of placed tensor");

    error_holds_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && status != trlp_pkg::ST_OK) |=> (cursor_reg == $past(cur)))
        else $error("cursor moved on a rejected plan");

    error_sets_abort: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && status != trlp_pkg::ST_OK) |=> aborted_reg)
        else $error("abort not held after error");

    first_clears_abort: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && plan_data.first) |-> (status != trlp_pkg::ST_ABORTED))
        else $error("new layout answered as aborted");

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_PERIOD = 20;
    localparam int PHASE_PLANS = 370;
    localparam int HOLD_CYCLES = 300;
    localparam int TIMEOUT_CYCLES = 400_000;
    localparam logic [63:0] END_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [trlp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [trlp_pkg::CFG_W-1:0] cfg_data;
    logic push;
    logic full;
    trlp_pkg::in_t in_item;
    logic empty;
    logic pop;
    trlp_pkg::out_t out_item;

    tensor_region_layout_planner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Layout state mirrored from the block
    logic [63:0] layout_cursor = '0;
    logic layout_aborted = 1'b0;
    logic [31:0] entries_cfg = '0;
    logic [31:0] name_bytes_cfg = '0;

    trlp_pkg::in_t plan_queue[$];
    trlp_pkg::out_t expected_offsets[$];
    logic plan_accepted = 1'b0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_results = 1'b0;
    int hold_cycles;
    int errors = 0;
    int plans_taken = 0;
    int results_checked = 0;
    int status_count[6];
    event hold_off_evt;

    function automatic trlp_pkg::out_t plan_layout(trlp_pkg::in_t p);
        trlp_pkg::out_t r;
        trlp_pkg::status_t st;
        logic [63:0] mask;
        logic [63:0] fa_mask;
        logic [63:0] start;
        logic [63:0] c;
        logic [64:0] sum;
        r = '0;
        st = trlp_pkg::ST_OK;
        if (p.first)
        begin
            fa_mask = 64'(trlp_pkg::FILE_ALIGN_DEF - 1);
            start = 64'(trlp_pkg::HEAD_BYTES_DEF)
                    + 64'(entries_cfg) * 64'(trlp_pkg::ENTRY_BYTES_DEF)
                    + 64'(name_bytes_cfg);
            layout_cursor = (start + fa_mask) & ~fa_mask;
            layout_aborted = 1'b0;
        end
        mask = 64'(p.align_bytes) - 64'd1;
        if (layout_aborted)
            st = trlp_pkg::ST_ABORTED;
        else if (p.payload_bytes == 64'd0 || p.dim_count > trlp_pkg::MAX_DIMS
                 || p.align_bytes < trlp_pkg::FILE_ALIGN_DEF
                 || (p.align_bytes & (p.align_bytes - 32'd1)) != 32'd0)
            st = trlp_pkg::ST_INVALID;
        else
        begin
            sum = {1'b0, layout_cursor} + {1'b0, mask};
            if (sum[64])
                st = trlp_pkg::ST_PAY_OVF;
            else
            begin
                c = sum[63:0] & ~mask;
                sum = {1'b0, c} + {1'b0, p.payload_bytes};
                if (sum[64])
                    st = trlp_pkg::ST_PAY_OVF;
                else
                begin
                    r.payload_offset = c;
                    c = sum[63:0];
                    if (p.side_bytes != 64'd0)
                    begin
                        sum = {1'b0, c} + {1'b0, mask};
                        if (sum[64])
                            st = trlp_pkg::ST_AUX_OVF;
                        else
                        begin
                            c = sum[63:0] & ~mask;
                            sum = {1'b0, c} + {1'b0, p.side_bytes};
                            if (sum[64])
                                st = trlp_pkg::ST_AUX_OVF;
                            else
                            begin
                                r.side_offset = c;
                                c = sum[63:0];
                            end
                        end
                    end
                    if (st == trlp_pkg::ST_OK && c > END_LIMIT)
                        st = trlp_pkg::ST_TOO_LARGE;
                    if (st == trlp_pkg::ST_OK)
                        layout_cursor = c;
                end
            end
        end
        if (st != trlp_pkg::ST_OK)
        begin
            r.payload_offset = '0;
            r.side_offset = '0;
            if (st != trlp_pkg::ST_ABORTED)
                layout_aborted = 1'b1;
        end
        r.status = st;
        r.end_offset = layout_cursor;
        return r;
    endfunction

    function automatic trlp_pkg::in_t make_plan(logic first, logic [63:0] pay,
                                                logic [63:0] side, logic [31:0] align,
                                                logic [3:0] dims);
        trlp_pkg::in_t p;
        p.first = first;
        p.payload_bytes = pay;
        p.side_bytes = side;
        p.align_bytes = align;
        p.dim_count = dims;
        return p;
    endfunction

    function automatic trlp_pkg::in_t random_plan(logic first);
        trlp_pkg::in_t p;
        int kind;
        kind = $urandom_range(0, 99);
        p.first = first;
        p.payload_bytes = 64'($urandom_range(1, 1 << 20));
        p.side_bytes = $urandom_range(0, 1) ? 64'd0 : 64'($urandom_range(1, 1 << 18));
        p.align_bytes = 32'd1 << $urandom_range(8, 16);
        p.dim_count = 4'($urandom_range(0, trlp_pkg::MAX_DIMS));
        if (kind >= 70 && kind < 78)
        begin
            // huge payloads push toward overflow and the end limit
            p.payload_bytes = {$urandom, $urandom};
            p.align_bytes = 32'd1 << $urandom_range(8, 31);
        end
        else if (kind >= 78 && kind < 84)
            p.payload_bytes = (64'd1 << $urandom_range(58, 62)) + 64'($urandom);
        else if (kind >= 84 && kind < 92)
        begin
            p.payload_bytes = $urandom_range(0, 3) == 0 ? 64'd0 : {$urandom, $urandom};
            p.align_bytes = $urandom;
            p.dim_count = 4'($urandom_range(0, 15));
        end
        else if (kind >= 92)
        begin
            p.side_bytes = {$urandom, $urandom};
            p.payload_bytes = {32'($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0), $urandom};
        end
        return p;
    endfunction

    task automatic queue_plan(trlp_pkg::in_t p);
        plan_queue = {plan_queue, p};
    endtask

    task automatic queue_layouts(int count);
        int left;
        int len;
        trlp_pkg::in_t p;
        left = count;
        while (left > 0)
        begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len && left > 0; i++)
            begin
                p = random_plan(i == 0);
                if ($urandom_range(0, 9) == 0)
                    p.first = 1'($urandom_range(0, 1));
                queue_plan(p);
                left--;
            end
        end
    endtask

    task automatic write_register(input logic [trlp_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == trlp_pkg::CFG_ENTRY_COUNT)
            entries_cfg = value;
        else if (idx == trlp_pkg::CFG_NAME_TABLE_BYTES)
            name_bytes_cfg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (plan_queue.size() != 0 || expected_offsets.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
        $display("%0t: %s mismatch, expected 0x%h actual 0x%h", $time, field, want, got);
        errors++;
    endtask

    // Request driver: offer the oldest pending plan, idling at random
    always @(negedge clk)
    begin
        if (plan_accepted)
        begin
            void'(plan_queue.pop_front());
            plan_accepted = 1'b0;
        end
        if (plan_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
        begin
            push <= 1'b1;
            in_item <= plan_queue[0];
        end
        else
            push <= 1'b0;
    end

    always @(negedge clk)
        pop <= !hold_results && ($urandom_range(0, 99) >= recv_stall_pct);

    // Long hold on the result side so the block backs up and raises full
    always
    begin
        @(hold_off_evt);
        hold_results <= 1'b1;
        for (hold_cycles = 0; hold_cycles < HOLD_CYCLES; hold_cycles++)
            @(negedge clk);
        hold_results <= 1'b0;
    end

    always @(posedge clk)
    begin : monitor
        trlp_pkg::out_t want;
        if (rst_n && push && !full)
        begin
            expected_offsets = {expected_offsets, plan_layout(in_item)};
            plan_accepted = 1'b1;
            plans_taken++;
        end
        if (rst_n && pop && !empty)
        begin
            if (out_item.status <= trlp_pkg::ST_ABORTED)
                status_count[out_item.status]++;
            if (expected_offsets.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d end 0x%h", $time,
                         out_item.status, out_item.end_offset);
                errors++;
            end
            else
            begin
                want = expected_offsets.pop_front();
                results_checked++;
                if (out_item.status !== want.status)
                    report_field("status", 64'(want.status), 64'(out_item.status));
                if (out_item.payload_offset !== want.payload_offset)
                    report_field("payload_offset", want.payload_offset,
                                 out_item.payload_offset);
                if (out_item.side_offset !== want.side_offset)
                    report_field("side_offset", want.side_offset, out_item.side_offset);
                if (out_item.end_offset !== want.end_offset)
                    report_field("end_offset", want.end_offset, out_item.end_offset);
            end
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("%0t: timeout, %0d results still pending", $time, expected_offsets.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = trlp_pkg::CFG_ENTRY_COUNT;
        cfg_data = '0;
        foreach (status_count[i])
            status_count[i] = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed plans, registers at their reset values
        queue_plan(make_plan(1'b0, 64'd1, 64'd0, 32'd256, 4'd0));
        queue_plan(make_plan(1'b1, 64'd1, 64'd0, 32'd256, 4'd4));
        queue_plan(make_plan(1'b0, 64'd0, 64'd0, 32'd256, 4'd1));
        queue_plan(make_plan(1'b0, 64'd5, 64'd0, 32'd256, 4'd1));
        queue_plan(make_plan(1'b1, 64'd5, 64'd0, 32'd256, 4'd5));
        queue_plan(make_plan(1'b1, 64'd5, 64'd0, 32'd256, 4'd15));
        queue_plan(make_plan(1'b1, 64'd5, 64'd0, 32'd255, 4'd2));
        queue_plan(make_plan(1'b1, 64'd5, 64'd0, 32'd384, 4'd2));
        queue_plan(make_plan(1'b1, 64'd5, 64'd0, 32'd0, 4'd2));
        queue_plan(make_plan(1'b1, 64'd1, 64'd1, 32'h8000_0000, 4'd3));
        queue_plan(make_plan(1'b0, 64'd100, 64'd7, 32'd4096, 4'd3));
        queue_plan(make_plan(1'b1, '1, 64'd0, 32'd256, 4'd1));
        queue_plan(make_plan(1'b1, 64'h8000_0000_0000_0000, 64'd0, 32'd256, 4'd1));
        queue_plan(make_plan(1'b1, 64'd1, '1, 32'd256, 4'd1));
        // payload ends just short of 2^64 so aligning the side region overflows
        queue_plan(make_plan(1'b1, 64'hFFFF_FFFF_FFFF_FE01, 64'd1, 32'd256, 4'd1));
        // end lands exactly on the limit, then one more byte is too large
        queue_plan(make_plan(1'b1, 64'h7FFF_FFFF_FFFF_FEFF, 64'd0, 32'd256, 4'd0));
        queue_plan(make_plan(1'b0, 64'd1, 64'd0, 32'd256, 4'd0));
        queue_plan(make_plan(1'b1, 64'h100, 64'h100, 32'd256, 4'd2));
        queue_plan(make_plan(1'b0, 64'd3, 64'h7FFF_0000_0000_0000, 32'd512, 4'd4));
        queue_plan(make_plan(1'b1, {$urandom, $urandom}, {$urandom, $urandom},
                             32'hFFFF_FFFF, 4'd15));
        queue_plan(make_plan(1'b1, 64'd9, 64'd9, 32'd1024, 4'd4));
        wait_drained();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    write_register(trlp_pkg::CFG_ENTRY_COUNT, 32'hFFFF_FFFF);
                    write_register(trlp_pkg::CFG_NAME_TABLE_BYTES, 32'hFFFF_FFFF);
                end
                1:
                begin
                    write_register(trlp_pkg::CFG_ENTRY_COUNT, 32'd0);
                    write_register(trlp_pkg::CFG_NAME_TABLE_BYTES, 32'd0);
                end
                2:
                begin
                    write_register(trlp_pkg::CFG_ENTRY_COUNT, 32'($urandom_range(0, 64)));
                    write_register(trlp_pkg::CFG_NAME_TABLE_BYTES,
                                   32'($urandom_range(0, 4096)));
                end
                3:
                begin
                    write_register(trlp_pkg::CFG_ENTRY_COUNT, $urandom);
                    write_register(trlp_pkg::CFG_NAME_TABLE_BYTES, $urandom);
                end
                default:
                begin
                    write_register(trlp_pkg::CFG_ENTRY_COUNT, 32'd1);
                    write_register(trlp_pkg::CFG_NAME_TABLE_BYTES, 32'd255);
                end
            endcase
            send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 84 : 32) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 84 : 32) : 0;
            queue_layouts(PHASE_PLANS);
            if (phase == 0)
                ->hold_off_evt;
            wait_drained();
        end

        repeat (8) @(posedge clk);
        $display("Checked %0d results for %0d plans over five register settings,",
                 results_checked, plans_taken);
        $display("idle/stall mixes, long hold; ok %0d bad %0d pay %0d aux %0d big %0d abort %0d",
                 status_count[0], status_count[1], status_count[2], status_count[3],
                 status_count[4], status_count[5]);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[tensor_region_layout_planner.f]
rtl/trlp_pkg.sv
rtl/trlp_fifo.sv
rtl/trlp_front.sv
rtl/trlp_back.sv
rtl/tensor_region_layout_planner.sv
bench/testbench.sv
